// ----- rtl/blhm_pkg.sv -----
package blhm_pkg;

    // Group size default
    localparam int SAMPLES_DEF = 10;

    // Field widths
    localparam int ADC_W      = 12;
    localparam int SUM_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 12;
    localparam int LVL_MV_W   = 13;
    localparam int HYST_W     = 10;
    localparam int OUT_MV_W   = 16;
    localparam int LEVEL_W    = 2;
    localparam int STATE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN     = 3'd0,
        REG_LEVEL1   = 3'd1,
        REG_LEVEL2   = 3'd2,
        REG_LEVEL3   = 3'd3,
        REG_HYST     = 3'd4,
        REG_CHARGE   = 3'd5
    } cfg_reg_t;

    // Register reset values
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd6971;
    localparam logic [LVL_MV_W-1:0] LEVEL1_RST = 13'd3680;
    localparam logic [LVL_MV_W-1:0] LEVEL2_RST = 13'd3780;
    localparam logic [LVL_MV_W-1:0] LEVEL3_RST = 13'd3880;
    localparam logic [HYST_W-1:0]   HYST_RST   = 10'd20;
    localparam logic [LVL_MV_W-1:0] CHARGE_RST = 13'd4300;

    // Charge state codes
    localparam logic [STATE_W-1:0] LEVEL_0     = 3'd0;
    localparam logic [STATE_W-1:0] LEVEL_1     = 3'd1;
    localparam logic [STATE_W-1:0] LEVEL_2     = 3'd2;
    localparam logic [STATE_W-1:0] LEVEL_3     = 3'd3;
    localparam logic [STATE_W-1:0] LEVEL_UNSET = 3'd4;

    // Configuration bundle
    typedef struct packed {
        logic [GAIN_W-1:0]   gain;
        logic [LVL_MV_W-1:0] level1;
        logic [LVL_MV_W-1:0] level2;
        logic [LVL_MV_W-1:0] level3;
        logic [HYST_W-1:0]   hyst;
        logic [LVL_MV_W-1:0] charge_thr;
    } cfg_t;

endpackage

// ----- rtl/blhm_cfg.sv -----
module blhm_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [blhm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [blhm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output blhm_pkg::cfg_t                   cfg
);

    blhm_pkg::cfg_t cfg_reg;
    blhm_pkg::cfg_t cfg_next;

    // Register decode; unknown indexes leave everything as is
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (blhm_pkg::cfg_reg_t'(cfg_index))
                blhm_pkg::REG_GAIN:
                    cfg_next.gain = cfg_data[blhm_pkg::GAIN_W-1:0];
                blhm_pkg::REG_LEVEL1:
                    cfg_next.level1 = cfg_data[blhm_pkg::LVL_MV_W-1:0];
                blhm_pkg::REG_LEVEL2:
                    cfg_next.level2 = cfg_data[blhm_pkg::LVL_MV_W-1:0];
                blhm_pkg::REG_LEVEL3:
                    cfg_next.level3 = cfg_data[blhm_pkg::LVL_MV_W-1:0];
                blhm_pkg::REG_HYST:
                    cfg_next.hyst = cfg_data[blhm_pkg::HYST_W-1:0];
                blhm_pkg::REG_CHARGE:
                    cfg_next.charge_thr = cfg_data[blhm_pkg::LVL_MV_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain       <= blhm_pkg::GAIN_RST;
            cfg_reg.level1     <= blhm_pkg::LEVEL1_RST;
            cfg_reg.level2     <= blhm_pkg::LEVEL2_RST;
            cfg_reg.level3     <= blhm_pkg::LEVEL3_RST;
            cfg_reg.hyst       <= blhm_pkg::HYST_RST;
            cfg_reg.charge_thr <= blhm_pkg::CHARGE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/blhm_acc.sv -----
module blhm_acc #(
    parameter int SAMPLES = blhm_pkg::SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [blhm_pkg::ADC_W-1:0]    adc_sample,
    output logic                          grp_valid,
    output logic [blhm_pkg::SUM_W-1:0]    grp_sum,
    input  logic                          grp_ready
);

    localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES - 1);

    logic [CNT_W-1:0]             count_reg, count_next;
    logic [blhm_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic                         grp_valid_reg, grp_valid_next;
    logic [blhm_pkg::SUM_W-1:0]   grp_sum_reg;
    logic [blhm_pkg::SUM_W-1:0]   sum_add;
    logic                         accept;
    logic                         last;

    // Hold off new samples only when the finished group cannot move on
    assign in_stall = grp_valid_reg && !grp_ready;
    assign accept   = in_valid && !in_stall;
    assign last     = (count_reg == LAST);
    assign sum_add  = sum_reg + blhm_pkg::SUM_W'(adc_sample);

    // Accumulate; restart after the last sample of a group
    always_comb
    begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        grp_valid_next = grp_ready ? 1'b0 : grp_valid_reg;
        if (accept)
        begin
            if (last)
            begin
                count_next     = '0;
                sum_next       = '0;
                grp_valid_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                sum_next   = sum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            grp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            grp_valid_reg <= grp_valid_next;
        end
    end

    // Group total
    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            grp_sum_reg <= sum_add;
        end
    end

    assign grp_valid = grp_valid_reg;
    assign grp_sum   = grp_sum_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST)
        else $error("sample count beyond group size");
`endif

endmodule

// ----- rtl/blhm_scale.sv -----
module blhm_scale #(
    parameter int SAMPLES = blhm_pkg::SAMPLES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  logic [blhm_pkg::SUM_W-1:0]     sum,
    input  logic [blhm_pkg::GAIN_W-1:0]    gain,
    output logic                           dn_valid,
    output logic [blhm_pkg::OUT_MV_W-1:0]  mv,
    input  logic                           dn_ready
);

    localparam int PROD_W   = blhm_pkg::SUM_W + blhm_pkg::GAIN_W;
    localparam int QIN_W    = PROD_W - blhm_pkg::GAIN_FRAC;
    localparam int SHIFT    = QIN_W + $clog2(SAMPLES);
    localparam int RECIP_W  = SHIFT + 1;
    localparam int MUL_W    = QIN_W + RECIP_W;
    localparam int QUO_W    = MUL_W - SHIFT;
    // ceil(2^SHIFT / SAMPLES): exact floor division for QIN_W-bit values
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

    logic                          prod_valid_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic                          mv_valid_reg;
    logic [blhm_pkg::OUT_MV_W-1:0] mv_reg;
    logic                          mv_ready;
    logic [PROD_W-1:0]             prod;
    logic [MUL_W-1:0]              quo_full;
    logic [QUO_W-1:0]              quo;

    assign mv_ready = !mv_valid_reg || dn_ready;
    assign up_ready = !prod_valid_reg || mv_ready;

    // Stage 1: sum times Q12 gain
    assign prod = PROD_W'(sum) * PROD_W'(gain);

    // Stage 2: drop the fraction, divide by group size via reciprocal
    assign quo_full = MUL_W'(prod_reg[PROD_W-1:blhm_pkg::GAIN_FRAC]) * MUL_W'(RECIP);
    assign quo      = quo_full[MUL_W-1:SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            mv_valid_reg   <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                prod_valid_reg <= up_valid;
            end
            if (mv_ready)
            begin
                mv_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            prod_reg <= prod;
        end
        if (mv_ready && prod_valid_reg)
        begin
            mv_reg <= quo[blhm_pkg::OUT_MV_W-1:0];
        end
    end

    assign dn_valid = mv_valid_reg;
    assign mv       = mv_reg;

`ifndef SYNTH
    a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg |-> (quo[QUO_W-1:blhm_pkg::OUT_MV_W] == '0))
        else $error("scaled voltage exceeds output width");
`endif

endmodule

// ----- rtl/blhm_level.sv -----
module blhm_level (
    input  logic                           clk,
    input  logic                           rst_n,
    input  blhm_pkg::cfg_t                 cfg,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  logic [blhm_pkg::OUT_MV_W-1:0]  mv,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [blhm_pkg::OUT_MV_W-1:0]  battery_mv,
    output logic [blhm_pkg::LEVEL_W-1:0]   charge_level,
    output logic                           charging
);

    localparam int CMP_W = blhm_pkg::OUT_MV_W + 2;

    logic [blhm_pkg::STATE_W-1:0]  level_state_reg, level_state_next;
    logic                          out_valid_reg;
    logic [blhm_pkg::OUT_MV_W-1:0] mv_out_reg;
    logic [blhm_pkg::LEVEL_W-1:0]  level_out_reg;
    logic                          charging_reg;
    logic                          fire;
    logic signed [CMP_W-1:0]       mv_s, hyst_s, l1_s, l2_s, l3_s;
    logic                          above1, above2, above3, below1, below2, below3;

    assign up_ready = !out_valid_reg || !out_stall;
    assign fire     = up_valid && up_ready;

    // Boundaries with hysteresis, signed so low boundaries do not wrap
    assign mv_s   = $signed(CMP_W'(mv));
    assign hyst_s = $signed(CMP_W'(cfg.hyst));
    assign l1_s   = $signed(CMP_W'(cfg.level1));
    assign l2_s   = $signed(CMP_W'(cfg.level2));
    assign l3_s   = $signed(CMP_W'(cfg.level3));
    assign above1 = mv_s > (l1_s + hyst_s);
    assign above2 = mv_s > (l2_s + hyst_s);
    assign above3 = mv_s > (l3_s + hyst_s);
    assign below1 = mv_s < (l1_s - hyst_s);
    assign below2 = mv_s < (l2_s - hyst_s);
    assign below3 = mv_s < (l3_s - hyst_s);

    // Charge state step; unset goes straight to state 0
    always_comb
    begin
        level_state_next = level_state_reg;
        if (fire)
        begin
            unique case (level_state_reg)
                blhm_pkg::LEVEL_0:
                begin
                    level_state_next = above1 ? blhm_pkg::LEVEL_1 : blhm_pkg::LEVEL_0;
                end
                blhm_pkg::LEVEL_1:
                begin
                    priority if (above2)
                        level_state_next = blhm_pkg::LEVEL_2;
                    else if (below1)
                        level_state_next = blhm_pkg::LEVEL_0;
                    else
                        level_state_next = blhm_pkg::LEVEL_1;
                end
                blhm_pkg::LEVEL_2:
                begin
                    priority if (above3)
                        level_state_next = blhm_pkg::LEVEL_3;
                    else if (below2)
                        level_state_next = blhm_pkg::LEVEL_1;
                    else
                        level_state_next = blhm_pkg::LEVEL_2;
                end
                blhm_pkg::LEVEL_3:
                begin
                    level_state_next = below3 ? blhm_pkg::LEVEL_2 : blhm_pkg::LEVEL_3;
                end
                default:
                begin
                    level_state_next = blhm_pkg::LEVEL_0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_state_reg <= blhm_pkg::LEVEL_UNSET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            level_state_reg <= level_state_next;
            if (up_ready)
            begin
                out_valid_reg <= up_valid;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            mv_out_reg    <= mv;
            level_out_reg <= level_state_next[blhm_pkg::LEVEL_W-1:0];
            charging_reg  <= (mv > blhm_pkg::OUT_MV_W'(cfg.charge_thr));
        end
    end

    assign out_valid    = out_valid_reg;
    assign battery_mv   = mv_out_reg;
    assign charge_level = level_out_reg;
    assign charging     = charging_reg;

`ifndef SYNTH
    a_state_set: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (level_state_reg != blhm_pkg::LEVEL_UNSET))
        else $error("charge state still unset after a measurement");

    a_state_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !level_state_reg[2]) |->
            ((level_state_next == level_state_reg) ||
             (level_state_next == level_state_reg + 3'd1) ||
             (level_state_next + 3'd1 == level_state_reg)))
        else $error("charge state moved by more than one step");

    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        level_state_reg <= blhm_pkg::LEVEL_UNSET)
        else $error("charge state holds a code above unset");
`endif

endmodule

// ----- rtl/battery_level_hysteresis_monitor_core.sv -----
// Battery level monitor with hysteresis.
// Input channel: one raw ADC sample per request (in_valid / in_stall).
// Every SAMPLES accepted samples form a group; the last sample of a group
// causes one result on the output channel (out_valid / out_stall):
// battery_mv = floor(sum * gain / (SAMPLES * 4096)), a two-bit charge state
// kept with hysteresis, and a charging flag. Other samples give no result.
// Throughput: one sample per cycle while in_stall is low, set by the accumulator.
// Path: the last sample of a group passes the group register, the gain
// multiply register, the reciprocal divide into the scale output register,
// and the level compare into the result register.
// Configuration: plain write port (cfg_we, cfg_index, cfg_data); write only
// while no group is in flight. Unknown indexes are ignored.
// Reset: registers take their default values, the sample count and sum
// clear, and the charge state becomes unset, so the first measurement sets
// state 0 without comparing.
// Stall: a stalled result holds; the two inner stages keep filling, and
// in_stall rises only when a finished group can no longer move forward.
module battery_level_hysteresis_monitor_core #(
    parameter int SAMPLES = blhm_pkg::SAMPLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [blhm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [blhm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [blhm_pkg::ADC_W-1:0]       adc_sample,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [blhm_pkg::OUT_MV_W-1:0]    battery_mv,
    output logic [blhm_pkg::LEVEL_W-1:0]     charge_level,
    output logic                             charging
);

    blhm_pkg::cfg_t                cfg;
    logic                          grp_valid;
    logic                          grp_ready;
    logic [blhm_pkg::SUM_W-1:0]    grp_sum;
    logic                          mv_valid;
    logic                          mv_ready;
    logic [blhm_pkg::OUT_MV_W-1:0] mv;

    // Register file
    blhm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sample accumulator
    blhm_acc #(
        .SAMPLES (SAMPLES)
    ) u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .adc_sample (adc_sample),
        .grp_valid  (grp_valid),
        .grp_sum    (grp_sum),
        .grp_ready  (grp_ready)
    );

    // Gain and averaging
    blhm_scale #(
        .SAMPLES (SAMPLES)
    ) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (grp_valid),
        .up_ready (grp_ready),
        .sum      (grp_sum),
        .gain     (cfg.gain),
        .dn_valid (mv_valid),
        .mv       (mv),
        .dn_ready (mv_ready)
    );

    // Charge state and result register
    blhm_level u_level (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .up_valid     (mv_valid),
        .up_ready     (mv_ready),
        .mv           (mv),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .battery_mv   (battery_mv),
        .charge_level (charge_level),
        .charging     (charging)
    );

endmodule

// ----- dv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import blhm_pkg::*;

    localparam int GROUP       = SAMPLES_DEF;
    localparam int SETTLE      = 10;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 10;
    localparam int ADC_MAX     = (1 << ADC_W) - 1;

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

    typedef struct {
        logic [OUT_MV_W-1:0] mv;
        logic [LEVEL_W-1:0]  level;
        logic                chg;
    } reading_t;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = REG_GAIN;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [ADC_W-1:0]      adc_sample = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [OUT_MV_W-1:0]   battery_mv;
    logic [LEVEL_W-1:0]    charge_level;
    logic                  charging;

    // Shadow configuration
    logic [GAIN_W-1:0]     cfg_gain   = GAIN_RST;
    logic [LVL_MV_W-1:0]   cfg_level1 = LEVEL1_RST;
    logic [LVL_MV_W-1:0]   cfg_level2 = LEVEL2_RST;
    logic [LVL_MV_W-1:0]   cfg_level3 = LEVEL3_RST;
    logic [HYST_W-1:0]     cfg_hyst   = HYST_RST;
    logic [LVL_MV_W-1:0]   cfg_charge = CHARGE_RST;

    // Shadow accumulator and charge state
    logic [SUM_W-1:0]      acc_sum    = '0;
    logic [4:0]            acc_cnt    = '0;
    logic [STATE_W-1:0]    lvl_state  = LEVEL_UNSET;

    logic [ADC_W-1:0]      pend_q[$];
    reading_t              readings_due[$];
    int                    n_queued   = 0;
    int                    n_accepted = 0;
    int                    n_errors   = 0;
    int                    n_cycles   = 0;
    bit                    idle_en    = 1'b1;
    bit                    hold_req   = 1'b0;
    int                    tx_gap     = 0;
    int                    rx_gap     = 0;
    int                    rx_hold    = 0;

    battery_level_hysteresis_monitor_core #(.SAMPLES(GROUP)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .adc_sample   (adc_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .battery_mv   (battery_mv),
        .charge_level (charge_level),
        .charging     (charging)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hysteresis step, signed so that level - hyst may go below zero
    function automatic logic [STATE_W-1:0] next_charge_state(logic [STATE_W-1:0] cur, int mv);
        int h;
        int b1;
        int b2;
        int b3;
        h  = int'(cfg_hyst);
        b1 = int'(cfg_level1);
        b2 = int'(cfg_level2);
        b3 = int'(cfg_level3);
        case (cur)
            LEVEL_0: return (mv > b1 + h) ? LEVEL_1 : LEVEL_0;
            LEVEL_1:
            begin
                if (mv > b2 + h) return LEVEL_2;
                if (mv < b1 - h) return LEVEL_0;
                return LEVEL_1;
            end
            LEVEL_2:
            begin
                if (mv > b3 + h) return LEVEL_3;
                if (mv < b2 - h) return LEVEL_1;
                return LEVEL_2;
            end
            LEVEL_3: return (mv < b3 - h) ? LEVEL_2 : LEVEL_3;
            default: return LEVEL_0;
        endcase
    endfunction

    // Accumulate one accepted sample; a full group yields one reading
    task automatic accumulate_sample(logic [ADC_W-1:0] s);
        longint prod;
        logic [OUT_MV_W-1:0] mv;
        reading_t r;
        acc_sum = acc_sum + s;
        acc_cnt = acc_cnt + 1'b1;
        if (acc_cnt >= GROUP)
        begin
            prod      = longint'(acc_sum) * longint'(cfg_gain);
            mv        = OUT_MV_W'(prod / (GROUP * 4096));
            acc_sum   = '0;
            acc_cnt   = '0;
            lvl_state = next_charge_state(lvl_state, int'(mv));
            r.mv      = mv;
            r.level   = lvl_state[LEVEL_W-1:0];
            r.chg     = (mv > cfg_charge);
            readings_due.push_back(r);
        end
    endtask

    task automatic flag_error(string msg);
        n_errors++;
        if (n_errors <= MAX_SHOWN)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Register write, mirrored into the shadow configuration
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_GAIN:   cfg_gain   = val[GAIN_W-1:0];
            REG_LEVEL1: cfg_level1 = val[LVL_MV_W-1:0];
            REG_LEVEL2: cfg_level2 = val[LVL_MV_W-1:0];
            REG_LEVEL3: cfg_level3 = val[LVL_MV_W-1:0];
            REG_HYST:   cfg_hyst   = val[HYST_W-1:0];
            REG_CHARGE: cfg_charge = val[LVL_MV_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_sample(int s);
        if (s < 0) s = 0;
        if (s > ADC_MAX) s = ADC_MAX;
        pend_q.push_back(ADC_W'(s));
        n_queued++;
    endtask

    task automatic queue_const_group(int s);
        repeat (GROUP) queue_sample(s);
    endtask

    // Group whose mean lands just around one of the boundaries
    task automatic queue_aimed_group();
        logic [LVL_MV_W-1:0] mark;
        int off;
        int target;
        int base;
        case ($urandom_range(0, 3))
            0:       mark = cfg_level1;
            1:       mark = cfg_level2;
            2:       mark = cfg_level3;
            default: mark = cfg_charge;
        endcase
        off    = int'(cfg_hyst) + int'($urandom_range(0, 6)) - 1;
        target = $urandom_range(0, 1) ? int'(mark) + off : int'(mark) - off;
        if (target < 0) target = 0;
        if (cfg_gain == '0)
            base = $urandom_range(0, ADC_MAX);
        else
            base = (target * 4096) / int'(cfg_gain);
        repeat (GROUP) queue_sample(base + int'($urandom_range(0, 4)) - 2);
    endtask

    task automatic queue_random_groups(int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                queue_aimed_group();
            else if (r == 7)
                repeat (GROUP) queue_sample($urandom_range(0, 1) ? ADC_MAX : 0);
            else
                repeat (GROUP) queue_sample($urandom_range(0, ADC_MAX));
        end
    endtask

    // Sender idle and every reading back, then let the pipeline settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (n_accepted != n_queued || readings_due.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Sequencer
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: first reading from the unset state, full scale, random groups
        queue_const_group(0);
        queue_const_group(ADC_MAX);
        queue_random_groups(16);
        wait_drained();

        // full gain, zero levels, widest hysteresis, zero charging threshold
        write_reg(REG_GAIN, 16'hFFFF);
        write_reg(REG_LEVEL1, 16'h0000);
        write_reg(REG_LEVEL2, 16'h0000);
        write_reg(REG_LEVEL3, 16'h0000);
        write_reg(REG_HYST, 16'hFFFF);
        write_reg(REG_CHARGE, 16'h0000);
        end_writes();
        queue_const_group(ADC_MAX);
        queue_random_groups(15);
        wait_drained();

        // zero gain, top levels, no hysteresis
        write_reg(REG_GAIN, 16'h0000);
        write_reg(REG_LEVEL1, 16'hFFFF);
        write_reg(REG_LEVEL2, 16'hFFFF);
        write_reg(REG_LEVEL3, 16'hFFFF);
        write_reg(REG_HYST, 16'h0000);
        write_reg(REG_CHARGE, 16'hFFFF);
        end_writes();
        queue_random_groups(12);
        wait_drained();

        // random contents, unused indexes, long receiver hold-off
        write_reg(REG_GAIN, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(REG_LEVEL1, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(REG_LEVEL2, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(REG_LEVEL3, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(REG_HYST, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(REG_CHARGE, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(IDX_SPARE_A, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(IDX_SPARE_B, CFG_DATA_W'($urandom_range(0, 65535)));
        end_writes();
        hold_req = 1'b1;
        queue_random_groups(20);
        wait_drained();

        // boundaries in descending order; sender pauses mid-group
        write_reg(REG_GAIN, GAIN_RST);
        write_reg(REG_LEVEL1, CFG_DATA_W'($urandom_range(4500, 6000)));
        write_reg(REG_LEVEL2, CFG_DATA_W'($urandom_range(3000, 4499)));
        write_reg(REG_LEVEL3, CFG_DATA_W'($urandom_range(1500, 2999)));
        write_reg(REG_HYST, CFG_DATA_W'($urandom_range(0, 300)));
        write_reg(REG_CHARGE, CFG_DATA_W'($urandom_range(0, 8191)));
        end_writes();
        queue_random_groups(10);
        repeat (GROUP / 2) queue_sample($urandom_range(0, ADC_MAX));
        do
            @(posedge clk);
        while (n_accepted != n_queued || readings_due.size() != 0);
        repeat (GROUP - GROUP / 2) queue_sample($urandom_range(0, ADC_MAX));
        queue_random_groups(9);
        wait_drained();

        // ordered levels around the working range, narrow hysteresis
        write_reg(REG_GAIN, CFG_DATA_W'($urandom_range(5000, 9000)));
        write_reg(REG_LEVEL1, CFG_DATA_W'($urandom_range(3000, 3600)));
        write_reg(REG_LEVEL2, CFG_DATA_W'(cfg_level1 + $urandom_range(50, 200)));
        write_reg(REG_LEVEL3, CFG_DATA_W'(cfg_level2 + $urandom_range(50, 200)));
        write_reg(REG_HYST, CFG_DATA_W'($urandom_range(0, 60)));
        write_reg(REG_CHARGE, CFG_DATA_W'($urandom_range(3800, 4400)));
        end_writes();
        queue_random_groups(25);
        wait_drained();

        // defaults back, no idling in the final stretch
        idle_en = 1'b0;
        write_reg(REG_GAIN, GAIN_RST);
        write_reg(REG_LEVEL1, CFG_DATA_W'(LEVEL1_RST));
        write_reg(REG_LEVEL2, CFG_DATA_W'(LEVEL2_RST));
        write_reg(REG_LEVEL3, CFG_DATA_W'(LEVEL3_RST));
        write_reg(REG_HYST, CFG_DATA_W'(HYST_RST));
        write_reg(REG_CHARGE, CFG_DATA_W'(CHARGE_RST));
        end_writes();
        queue_random_groups(20);
        wait_drained();

        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Sample driver: predicts on acceptance, holds a stalled request
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            accumulate_sample(adc_sample);
            void'(pend_q.pop_front());
            n_accepted++;
        end
        if (!(in_valid && in_stall))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (pend_q.size() == 0)
                in_valid <= 1'b0;
            else if (idle_en && $urandom_range(0, 11) == 0)
            begin
                tx_gap = $urandom_range(0, 16);
                in_valid <= 1'b0;
            end
            else
            begin
                in_valid   <= 1'b1;
                adc_sample <= pend_q[0];
            end
        end
    end

    // Receiver stall: random bursts, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            rx_hold  = LONG_HOLD;
        end
        if (rx_hold > 0)
        begin
            rx_hold--;
            out_stall <= 1'b1;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_stall <= 1'b1;
        end
        else if (idle_en && $urandom_range(0, 9) == 0)
        begin
            rx_gap = $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Reading monitor
    always @(posedge clk)
    begin : mon
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (readings_due.size() == 0)
                flag_error($sformatf("reading with none due: mv %0d level %0d charging %0d",
                                     battery_mv, charge_level, charging));
            else
            begin
                want = readings_due.pop_front();
                if (battery_mv !== want.mv)
                    flag_error($sformatf("battery_mv exp %0d got %0d", want.mv, battery_mv));
                if (charge_level !== want.level)
                    flag_error($sformatf("charge_level exp %0d got %0d (mv %0d)",
                                         want.level, charge_level, want.mv));
                if (charging !== want.chg)
                    flag_error($sformatf("charging exp %0d got %0d (mv %0d)",
                                         want.chg, charging, want.mv));
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
